>>> rtl/irpir_pkg.sv
// Package for the infrared pulse-interval receiver: phase codes, interval
// windows and the beat payload types of the request and response channels.
// Depends on nothing; irpir_step and the core import it.
package irpir_pkg;

   // Decoder phases, in the encoding that the response beat reports.
   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_HDR_SPACE = 2'd1,
      PH_BIT_MARK  = 2'd2,
      PH_BIT_SPACE = 2'd3
   } phase_type;

   // Interval windows in microseconds, exclusive at both ends.
   localparam logic [31:0] HDR_MARK_LO  = 32'd8800;
   localparam logic [31:0] HDR_MARK_HI  = 32'd9200;
   localparam logic [31:0] HDR_SPACE_LO = 32'd4300;
   localparam logic [31:0] HDR_SPACE_HI = 32'd4700;
   localparam logic [31:0] BIT_MARK_LO  = 32'd560;
   localparam logic [31:0] BIT_MARK_HI  = 32'd640;
   localparam logic [31:0] ONE_LO       = 32'd950;
   localparam logic [31:0] ONE_HI       = 32'd1050;
   localparam logic [31:0] ZERO_LO      = 32'd1900;
   localparam logic [31:0] ZERO_HI      = 32'd2100;

   typedef struct packed {
      logic [31:0] edge_time;
   } req_payload_type;

   typedef struct packed {
      logic       word_done;
      logic [3:0] word_bits;
      logic [1:0] phase;
      logic [2:0] bits_received;
   } rsp_payload_type;

endpackage

>>> rtl/irpir_stream_if.sv
// Valid/ready stream interface used by both channels of the receiver.
// The payload type is a parameter; the package supplies the beat structs.
interface irpir_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/irpir_step.sv
// Next-state and result logic of the receiver for one edge timestamp.
// Depends on irpir_pkg for the phase codes, windows and response beat type.
module irpir_step import irpir_pkg::*; #(
   parameter int unsigned BITS = 4
) (
   input  logic [31:0]                  edge_time,
   input  logic [31:0]                  last_time_cur,
   input  phase_type                    phase_cur,
   input  logic [$clog2(BITS+1)-1:0]    bit_index_cur,
   input  logic [BITS-1:0]              word_cur,
   output phase_type                    phase_nxt,
   output logic [$clog2(BITS+1)-1:0]    bit_index_nxt,
   output logic [BITS-1:0]              word_nxt,
   output rsp_payload_type              result
);

   localparam int unsigned IDX_W = $clog2(BITS + 1);

   logic [31:0]      interval;
   logic             in_hdr_mark;
   logic             in_hdr_space;
   logic             in_bit_mark;
   logic             in_one;
   logic             in_zero;
   logic [IDX_W-1:0] index_inc;
   logic [IDX_W-1:0] shown_count;
   logic [BITS-1:0]  bit_set;
   logic             done;

   // The subtraction wraps modulo 2^32 by itself.
   assign interval     = edge_time - last_time_cur;
   assign in_hdr_mark  = (interval > HDR_MARK_LO)  && (interval < HDR_MARK_HI);
   assign in_hdr_space = (interval > HDR_SPACE_LO) && (interval < HDR_SPACE_HI);
   assign in_bit_mark  = (interval > BIT_MARK_LO)  && (interval < BIT_MARK_HI);
   assign in_one       = (interval > ONE_LO)       && (interval < ONE_HI);
   assign in_zero      = (interval > ZERO_LO)      && (interval < ZERO_HI);
   assign index_inc    = bit_index_cur + IDX_W'(1);

   // One-hot select of the bit being stored.
   always_comb begin
      for (int i = 0; i < int'(BITS); i++) begin
         bit_set[i] = (bit_index_cur == IDX_W'(i));
      end
   end

   always_comb begin
      phase_nxt     = PH_IDLE;
      bit_index_nxt = bit_index_cur;
      word_nxt      = word_cur;
      shown_count   = bit_index_cur;
      done          = 1'b0;
      unique case (phase_cur)
         PH_IDLE: begin
            if (in_hdr_mark) begin
               phase_nxt = PH_HDR_SPACE;
            end
         end
         PH_HDR_SPACE: begin
            if (in_hdr_space) begin
               phase_nxt     = PH_BIT_MARK;
               bit_index_nxt = '0;
               word_nxt      = '0;
               shown_count   = '0;
            end
         end
         PH_BIT_MARK: begin
            if (in_bit_mark) begin
               phase_nxt = PH_BIT_SPACE;
            end
         end
         PH_BIT_SPACE: begin
            if (in_one || in_zero) begin
               word_nxt    = in_one ? (word_cur | bit_set) : (word_cur & ~bit_set);
               shown_count = index_inc;
               if (index_inc == IDX_W'(BITS)) begin
                  done          = 1'b1;
                  phase_nxt     = PH_IDLE;
                  bit_index_nxt = '0;
               end else begin
                  phase_nxt     = PH_BIT_MARK;
                  bit_index_nxt = index_inc;
               end
            end
         end
         default: begin
            phase_nxt = PH_IDLE;
         end
      endcase
   end

   logic [31:0] word_wide;
   logic [31:0] count_wide;

   assign word_wide  = 32'(word_nxt);
   assign count_wide = 32'(shown_count);

   always_comb begin
      result.word_done     = done;
      result.word_bits     = word_wide[3:0];
      result.phase         = phase_nxt;
      result.bits_received = count_wide[2:0];
   end

endmodule

>>> rtl/ir_pulse_interval_receiver_core.sv
// Top level of the infrared pulse-interval receiver: input register, decoder
// state and response register. Depends on irpir_pkg, irpir_stream_if, irpir_step.
//
// Usage: req_if carries one beat per infrared edge, the 32-bit microsecond
// timer value captured at that edge. rsp_if returns exactly one beat per
// request beat, in order: word_done, the low four bits of the word store, the
// decoder phase after the edge and the low three bits of the bit count. A
// header mark, a header space, and then BITS pairs of bit mark and bit space
// make one word; any interval outside its window sends the decoder to idle.
// Pipeline and throughput: a request beat accepted into the request register
// moves on into the response register, and so onto rsp_if, when that register
// is free (two register stages: the request register, then the response
// register, with the interval subtract and the window compares between them).
// One beat is accepted every cycle as long as the sink keeps taking responses.
// Reset and stalls: a synchronous, active-high reset empties both stages and
// clears the decoder: idle phase, bit count zero, word zero, previous edge
// time zero. When the sink holds rsp_if.ready low, the response register
// holds its beat, the request register fills behind it, and req_if.ready
// drops once both stages are full; nothing is lost or repeated.
module ir_pulse_interval_receiver_core import irpir_pkg::*; #(
   parameter int unsigned BITS = 4
) (
   input logic            clock,
   input logic            reset,
   irpir_stream_if.sink   req_if,
   irpir_stream_if.source rsp_if
);

   localparam int unsigned IDX_W = $clog2(BITS + 1);

   // Request stage.
   logic                 req_valid_ff;
   logic                 req_valid_in;
   logic [31:0]          req_time_ff;

   // Response stage.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_payload_type      rsp_data_ff;

   // Decoder state, updated when a beat moves from the request stage into
   // the response stage.
   phase_type            phase_ff;
   phase_type            phase_in;
   logic [IDX_W-1:0]     bit_index_ff;
   logic [IDX_W-1:0]     bit_index_in;
   logic [BITS-1:0]      word_ff;
   logic [BITS-1:0]      word_in;
   logic [31:0]          last_time_ff;

   rsp_payload_type      step_result;
   logic                 rsp_free;
   logic                 advance;
   logic                 req_take;

   // The response register can load when it is empty or being drained this
   // cycle; the request register can load when it is empty or moving on.
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign advance   = req_valid_ff && rsp_free;
   assign req_take  = req_if.valid && req_if.ready;

   assign req_if.ready   = !req_valid_ff || rsp_free;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   irpir_step #(
      .BITS (BITS)
   ) u_step (
      .edge_time     (req_time_ff),
      .last_time_cur (last_time_ff),
      .phase_cur     (phase_ff),
      .bit_index_cur (bit_index_ff),
      .word_cur      (word_ff),
      .phase_nxt     (phase_in),
      .bit_index_nxt (bit_index_in),
      .word_nxt      (word_in),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_time_ff <= req_if.payload.edge_time;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   // Decoder state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= '0;
         word_ff      <= '0;
         last_time_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         word_ff      <= word_in;
         last_time_ff <= req_time_ff;
      end
   end

   // The stored bit count never reaches BITS: a full word clears it.
   a_index_below_bits: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff < IDX_W'(BITS))
      else $error("bit index reached the word length");

   // A completed word always leaves the decoder idle.
   a_done_means_idle: assert property (@(posedge clock) disable iff (reset)
      advance && step_result.word_done |=> phase_ff == PH_IDLE && bit_index_ff == '0)
      else $error("decoder not idle after a completed word");

   // A beat leaving the request stage lands in the response stage.
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response stage empty after an advance");

   // A valid header space starts a fresh word.
   a_header_clears_word: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_HDR_SPACE && phase_in == PH_BIT_MARK
      |=> bit_index_ff == '0 && word_ff == '0)
      else $error("word not cleared after header space");

   // The state only moves when a beat advances.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(last_time_ff))
      else $error("decoder state changed without a beat");

endmodule
